FILE: rtl/core/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared types and constants of the stereo gain ramp: field widths, reset
// values, register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package sgr_pkg;

  // Field widths fixed by the stream format
  localparam int SampleWidth = 16;
  localparam int PctWidth    = 7;
  localparam int StepWidth   = 17;
  localparam int IndexWidth  = 2;

  // Gain format default and percent scale
  localparam int DefGainFracBits = 16;
  localparam int PctScale        = 100;
  localparam int PctMax          = 100;

  // Register reset values
  localparam logic                 EnableReset  = 1'b0;
  localparam logic [PctWidth-1:0]  AmpPctReset  = PctWidth'(30);
  localparam logic [StepWidth-1:0] RampStepReset = StepWidth'(149);

  // Register indexes
  typedef enum logic [IndexWidth-1:0] {
    RegEnable     = 2'd0,
    RegAmpPercent = 2'd1,
    RegRampStep   = 2'd2
  } cfg_reg_e;

  // Configuration bundle handed to the gain ramp
  typedef struct packed {
    logic                 enable;
    logic [PctWidth-1:0]  amp_percent;
    logic [StepWidth-1:0] ramp_step;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/stereo_gain_ramp.sv
// Path: a request taken enters the input register, passes the multiply and
// then moves into the result register once that register is free.
// Throughput: 1 frame per cycle unless the sink stalls; the two-register
// pipeline advances whenever the result register is empty or being taken.
// Reset: asynchronous, active low; gain returns to silence, registers to
// their defaults (disabled, 30 percent, step 149), pipeline empties.
// ----------------------------------------------------------------------------
// stereo_gain_ramp
// Stereo gain stage with a linear click-suppressing ramp: each frame steps
// the gain toward its target, then scales, rounds and saturates both samples.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_gain_ramp #(
  parameter int GainFracBits = sgr_pkg::DefGainFracBits
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  // configuration
  input  wire                                     cfg_we_i,
  input  wire         [sgr_pkg::IndexWidth-1:0]   cfg_index_i,
  input  wire         [sgr_pkg::StepWidth-1:0]    cfg_data_i,
  // input frames
  input  wire                                     in_valid_i,
  output logic                                    in_ready_o,
  input  wire  signed [sgr_pkg::SampleWidth-1:0]  left_in_i,
  input  wire  signed [sgr_pkg::SampleWidth-1:0]  right_in_i,
  input  wire                                     buffer_end_i,
  // output frames
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output logic signed [sgr_pkg::SampleWidth-1:0]  left_out_o,
  output logic signed [sgr_pkg::SampleWidth-1:0]  right_out_o,
  output logic                                    buffer_end_out_o
);

  localparam int SW = sgr_pkg::SampleWidth;

  sgr_pkg::cfg_t cfg_q;

  logic                 s1_valid_q;
  logic signed [SW-1:0] s1_left_q, s1_right_q;
  logic                 s1_end_q;
  logic                 out_valid_q;
  logic signed [SW-1:0] out_left_q, out_right_q;
  logic                 out_end_q;

  logic                 out_free;
  logic                 in_take;
  logic [GainFracBits:0] gain;
  logic signed [SW-1:0] left_scaled, right_scaled;

  // Write configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable      <= sgr_pkg::EnableReset;
      cfg_q.amp_percent <= sgr_pkg::AmpPctReset;
      cfg_q.ramp_step   <= sgr_pkg::RampStepReset;
    end else if (cfg_we_i) begin
      case (sgr_pkg::cfg_reg_e'(cfg_index_i))
        sgr_pkg::RegEnable:     cfg_q.enable      <= cfg_data_i[0];
        sgr_pkg::RegAmpPercent: cfg_q.amp_percent <= cfg_data_i[sgr_pkg::PctWidth-1:0];
        sgr_pkg::RegRampStep:   cfg_q.ramp_step   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: each stage advances when the one after it can take
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;

  // Advance the gain with every accepted request
  sgr_gain_ramp #(
    .GainFracBits(GainFracBits)
  ) u_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(in_take),
    .cfg_i    (cfg_q),
    .gain_o   (gain)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_left_q  <= left_in_i;
      s1_right_q <= right_in_i;
      s1_end_q   <= buffer_end_i;
    end
  end

  // Scale both channels by the gain that belongs to the held frame
  sgr_scale #(
    .GainFracBits(GainFracBits)
  ) u_scale_left (
    .sample_i(s1_left_q),
    .gain_i  (gain),
    .scaled_o(left_scaled)
  );

  sgr_scale #(
    .GainFracBits(GainFracBits)
  ) u_scale_right (
    .sample_i(s1_right_q),
    .gain_i  (gain),
    .scaled_o(right_scaled)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_left_q  <= left_scaled;
      out_right_q <= right_scaled;
      out_end_q   <= s1_end_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_out_o       = out_left_q;
  assign right_out_o      = out_right_q;
  assign buffer_end_out_o = out_end_q;

endmodule

`default_nettype wire

FILE: rtl/core/sgr_gain_ramp.sv
// ----------------------------------------------------------------------------
// sgr_gain_ramp
// Smoothed gain register: on every accepted request the gain moves one ramp
// step toward the target gain and lands on it without overshoot.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_gain_ramp #(
  parameter int GainFracBits = sgr_pkg::DefGainFracBits
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       advance_i,
  input  wire sgr_pkg::cfg_t        cfg_i,
  output logic [GainFracBits:0]     gain_o
);

  localparam int GainWidth = GainFracBits + 1;
  localparam int CmpWidth  = (GainWidth > sgr_pkg::StepWidth) ? GainWidth
                                                               : sgr_pkg::StepWidth;
  localparam int TblDepth  = 2 ** sgr_pkg::PctWidth;

  logic [GainWidth-1:0] target_tbl [TblDepth];
  logic [GainWidth-1:0] target;
  logic [GainWidth-1:0] diff;
  logic                 near;
  logic [GainWidth-1:0] gain_d, gain_q;

  // Build the percent-to-gain table, clamping percent above full scale
  for (genvar i = 0; i < TblDepth; i++) begin : g_tbl
    localparam longint Pct = (i > sgr_pkg::PctMax) ? sgr_pkg::PctMax : i;
    localparam longint Val = (Pct << GainFracBits) / sgr_pkg::PctScale;
    assign target_tbl[i] = GainWidth'(Val);
  end

  // Step toward the target, landing on it when within one step
  always_comb begin
    target = cfg_i.enable ? target_tbl[cfg_i.amp_percent] : '0;
    diff   = (gain_q < target) ? GainWidth'(target - gain_q)
                               : GainWidth'(gain_q - target);
    near   = CmpWidth'(diff) <= CmpWidth'(cfg_i.ramp_step);
    if (near) begin
      gain_d = target;
    end else if (gain_q < target) begin
      gain_d = GainWidth'(CmpWidth'(gain_q) + CmpWidth'(cfg_i.ramp_step));
    end else begin
      gain_d = GainWidth'(CmpWidth'(gain_q) - CmpWidth'(cfg_i.ramp_step));
    end
  end

  // Hold the gain between requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
    end else if (advance_i) begin
      gain_q <= gain_d;
    end
  end

  assign gain_o = gain_q;

endmodule

`default_nettype wire

FILE: rtl/core/sgr_scale.sv
// ----------------------------------------------------------------------------
// sgr_scale
// Multiply one signed sample by the unsigned gain, round half away from
// zero and saturate to the sample width.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_scale #(
  parameter int GainFracBits = sgr_pkg::DefGainFracBits
) (
  input  wire  signed [sgr_pkg::SampleWidth-1:0] sample_i,
  input  wire         [GainFracBits:0]           gain_i,
  output logic signed [sgr_pkg::SampleWidth-1:0] scaled_o
);

  localparam int SW        = sgr_pkg::SampleWidth;
  localparam int MagWidth  = SW + 1;
  localparam int GainWidth = GainFracBits + 1;
  localparam int ProdWidth = MagWidth + GainWidth;
  localparam int RndWidth  = ProdWidth + 1;
  localparam int ResWidth  = RndWidth - GainFracBits;
  localparam logic [RndWidth-1:0] Half    = RndWidth'(1) << (GainFracBits - 1);
  localparam logic [ResWidth-1:0] PosMax  = ResWidth'((1 << (SW - 1)) - 1);
  localparam logic [ResWidth-1:0] NegMax  = ResWidth'(1 << (SW - 1));

  logic                 neg;
  logic [MagWidth-1:0]  mag;
  logic [ProdWidth-1:0] prod;
  logic [RndWidth-1:0]  rnd;
  logic [ResWidth-1:0]  res;
  logic [MagWidth-1:0]  lim;

  // Work on the magnitude so rounding is symmetric about zero
  always_comb begin
    neg  = sample_i[SW-1];
    mag  = neg ? MagWidth'(-{1'b1, sample_i}) : {1'b0, sample_i};
    prod = ProdWidth'(mag) * ProdWidth'(gain_i);
    rnd  = RndWidth'(prod) + Half;
    res  = ResWidth'(rnd >> GainFracBits);
    if (neg) begin
      lim      = (res > NegMax) ? MagWidth'(NegMax) : MagWidth'(res);
      scaled_o = SW'(MagWidth'(0) - lim);
    end else begin
      lim      = (res > PosMax) ? MagWidth'(PosMax) : MagWidth'(res);
      scaled_o = SW'(lim);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sgr_checker.sv
// ----------------------------------------------------------------------------
// sgr_port_checks
// Port-level checks of the stereo gain ramp, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_port_checks (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_valid_i,
  input wire                               in_ready_o,
  input wire                               out_valid_o,
  input wire                               out_ready_i,
  input wire [sgr_pkg::SampleWidth-1:0]    left_out_o,
  input wire [sgr_pkg::SampleWidth-1:0]    right_out_o,
  input wire                               buffer_end_out_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(left_out_o) && $stable(right_out_o) &&
      $stable(buffer_end_out_o))
    else $error("stalled result changed");

  // An empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output empty");

  // A result only appears once a taken request has passed the input register
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a request");

endmodule

bind stereo_gain_ramp sgr_port_checks u_sgr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .left_out_o      (left_out_o),
  .right_out_o     (right_out_o),
  .buffer_end_out_o(buffer_end_out_o)
);

`default_nettype wire

FILE: sim/sgr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sgr_checker
// Watches the configuration port and both frame channels of the stereo gain
// ramp. Keeps its own copy of the registers and the smoothed gain, works out
// the scaled frame for every accepted request and compares each accepted
// output frame, field by field, with the oldest frame still owed.
// ----------------------------------------------------------------------------
module sgr_checker #(
  parameter int GainFracBits = sgr_pkg::DefGainFracBits
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic        [sgr_pkg::IndexWidth-1:0]  cfg_index_i,
  input  logic        [sgr_pkg::StepWidth-1:0]   cfg_data_i,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_i,
  input  logic signed [sgr_pkg::SampleWidth-1:0] left_in_i,
  input  logic signed [sgr_pkg::SampleWidth-1:0] right_in_i,
  input  logic                                   buffer_end_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_ready_i,
  input  logic signed [sgr_pkg::SampleWidth-1:0] left_out_i,
  input  logic signed [sgr_pkg::SampleWidth-1:0] right_out_i,
  input  logic                                   buffer_end_out_i,
  output int                                     pending_o,
  output int                                     errors_o
);
  import sgr_pkg::*;

  localparam int GainWidth = GainFracBits + 1;

  typedef struct packed {
    logic signed [SampleWidth-1:0] left;
    logic signed [SampleWidth-1:0] right;
    logic                          buffer_end;
  } frame_t;

  cfg_t                 regs_q;
  logic [GainWidth-1:0] gain_q;
  frame_t               owed_frames_q[$];

  // Move the gain one step toward its target, landing on it rather than past
  function automatic logic [GainWidth-1:0] ramp_gain(logic [GainWidth-1:0] gain, cfg_t regs);
    logic [PctWidth-1:0]  pct;
    logic [GainWidth-1:0] target;
    pct    = (regs.amp_percent > PctMax) ? PctWidth'(PctMax) : regs.amp_percent;
    target = regs.enable ? GainWidth'((64'(pct) << GainFracBits) / PctScale) : '0;
    if (gain < target) begin
      if (target - gain <= regs.ramp_step) return target;
      return gain + GainWidth'(regs.ramp_step);
    end
    if (gain > target) begin
      if (gain - target <= regs.ramp_step) return target;
      return gain - GainWidth'(regs.ramp_step);
    end
    return gain;
  endfunction

  // Scale one sample by magnitude, round half away from zero, clamp to 16 bits
  function automatic logic signed [SampleWidth-1:0] scale_sample(
    logic signed [SampleWidth-1:0] smp, logic [GainWidth-1:0] gain);
    longint mag;
    longint g;
    longint r;
    mag = smp;
    g   = gain;
    if (mag < 0) mag = -mag;
    r = (mag * g + (64'd1 << (GainFracBits - 1))) >>> GainFracBits;
    if (smp < 0) begin
      if (r > 32768) r = 32768;
      return SampleWidth'(-r);
    end
    if (r > 32767) r = 32767;
    return SampleWidth'(r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : observe
    frame_t want;
    if (!rst_ni) begin
      regs_q.enable      = EnableReset;
      regs_q.amp_percent = AmpPctReset;
      regs_q.ramp_step   = RampStepReset;
      gain_q             = '0;
      owed_frames_q.delete();
      errors_o           = 0;
    end else begin
      // Track register writes, keeping only each register's width
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegEnable:     regs_q.enable      = cfg_data_i[0];
          RegAmpPercent: regs_q.amp_percent = cfg_data_i[PctWidth-1:0];
          RegRampStep:   regs_q.ramp_step   = cfg_data_i;
          default: ;
        endcase
      end
      // Advance the gain and queue the scaled frame for each request
      if (in_valid_i && in_ready_i) begin
        gain_q          = ramp_gain(gain_q, regs_q);
        want.left       = scale_sample(left_in_i, gain_q);
        want.right      = scale_sample(right_in_i, gain_q);
        want.buffer_end = buffer_end_i;
        owed_frames_q.push_back(want);
      end
      // Compare each output frame with the oldest one owed
      if (out_valid_i && out_ready_i) begin
        if (owed_frames_q.size() == 0) begin
          $error("output frame accepted with none owed");
          errors_o++;
        end else begin
          want = owed_frames_q.pop_front();
          if (left_out_i !== want.left) begin
            $error("left_out: expected %0d, got %0d", want.left, left_out_i);
            errors_o++;
          end
          if (right_out_i !== want.right) begin
            $error("right_out: expected %0d, got %0d", want.right, right_out_i);
            errors_o++;
          end
          if (buffer_end_out_i !== want.buffer_end) begin
            $error("buffer_end_out: expected %0d, got %0d", want.buffer_end,
                   buffer_end_out_i);
            errors_o++;
          end
        end
      end
    end
    pending_o = owed_frames_q.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the stereo gain ramp: directed register settings and frames
// for silence, unity, clamped percent, frozen gain, ramps and exact landing,
// then random settings with random frames, bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb;
  import sgr_pkg::*;

  // Index with no register behind it
  localparam logic [IndexWidth-1:0] RegUnused = 2'd3;
  localparam int FrameTarget = 1050;
  localparam int IdleLimit   = 4000;

  typedef enum int {SinkOpen, SinkCoin, SinkSlow, SinkPulse} sink_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [IndexWidth-1:0]         cfg_index_i;
  logic [StepWidth-1:0]          cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [SampleWidth-1:0] left_in_i;
  logic signed [SampleWidth-1:0] right_in_i;
  logic                          buffer_end_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic signed [SampleWidth-1:0] left_out_o;
  logic signed [SampleWidth-1:0] right_out_o;
  logic                          buffer_end_out_o;

  int frames_owed;
  int mismatches;
  int frames_sent;
  int burst_left;

  stereo_gain_ramp i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .left_in_i        (left_in_i),
    .right_in_i       (right_in_i),
    .buffer_end_i     (buffer_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_out_o       (left_out_o),
    .right_out_o      (right_out_o),
    .buffer_end_out_o (buffer_end_out_o)
  );

  sgr_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .left_in_i        (left_in_i),
    .right_in_i       (right_in_i),
    .buffer_end_i     (buffer_end_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .left_out_i       (left_out_o),
    .right_out_i      (right_out_o),
    .buffer_end_out_i (buffer_end_out_o),
    .pending_o        (frames_owed),
    .errors_o         (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Favour full-scale and near-zero samples now and then
  function automatic logic signed [SampleWidth-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      3:       return '1;
      default: return SampleWidth'($urandom);
    endcase
  endfunction

  // Present one frame request and hold it until taken; open gaps between bursts
  task automatic send_frame(input logic signed [SampleWidth-1:0] left,
                            input logic signed [SampleWidth-1:0] right,
                            input logic last);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    left_in_i    <= left;
    right_in_i   <= right;
    buffer_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    frames_sent++;
  endtask

  // Drain the pipeline, then write all three registers back to back
  task automatic set_regs(input logic [StepWidth-1:0] en_word,
                          input logic [StepWidth-1:0] pct_word,
                          input logic [StepWidth-1:0] step_word,
                          input bit poke_unused);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frames_owed != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegEnable;
    cfg_data_i  <= en_word;
    @(negedge clk_i);
    cfg_index_i <= RegAmpPercent;
    cfg_data_i  <= pct_word;
    @(negedge clk_i);
    cfg_index_i <= RegRampStep;
    cfg_data_i  <= step_word;
    @(negedge clk_i);
    if (poke_unused) begin
      cfg_index_i <= RegUnused;
      cfg_data_i  <= StepWidth'($urandom);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Sink: switch between ready patterns every so often
  initial begin : sink
    sink_mode_e mode;
    int         span;
    int         tick;
    out_ready_i = 1'b0;
    tick = 0;
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          SinkOpen:  out_ready_i <= 1'b1;
          SinkCoin:  out_ready_i <= 1'($urandom_range(0, 1));
          SinkSlow:  out_ready_i <= ($urandom_range(0, 4) == 0);
          SinkPulse: out_ready_i <= (tick % 4 != 0);
          default:   out_ready_i <= 1'b1;
        endcase
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no request moving
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int                   span;
    logic                 en;
    logic [PctWidth-1:0]  pct;
    logic [StepWidth-1:0] step;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = RegEnable;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    left_in_i    = '0;
    right_in_i   = '0;
    buffer_end_i = 1'b0;
    burst_left   = 0;
    frames_sent  = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: disabled, gain stays silent
    send_frame(16'sh7fff, 16'sh8000, 1'b0);
    send_frame(-16'sd1, 16'sd1, 1'b1);

    // Unity in a single step, full-scale samples pass unchanged
    set_regs(17'h00001, 17'd100, 17'h10000, 1'b0);
    send_frame(16'sh7fff, 16'sh8000, 1'b1);
    send_frame(16'sh8000, 16'sh7fff, 1'b0);
    send_frame(16'sd0, -16'sd1, 1'b1);
    send_frame(16'sd1, -16'sd2, 1'b0);

    // Percent above hundred clamps; widest step; upper data bits dropped
    set_regs(17'h1fff1, 17'h1ff7f, 17'h1ffff, 1'b0);
    send_frame(16'sh5555, -16'sh5556, 1'b0);
    send_frame(16'sh7ffe, 16'sh8001, 1'b1);

    // Zero step freezes the gain even though disabled
    set_regs(17'h00000, 17'd100, 17'h00000, 1'b0);
    send_frame(16'sh7fff, 16'sh8000, 1'b0);
    send_frame(16'sh1234, -16'sh1234, 1'b0);

    // Ramp down toward silence; write to the unused index is ignored
    set_regs(17'h1fffe, 17'd100, 17'd149, 1'b1);
    send_frame(16'sh7fff, 16'sh8000, 1'b0);
    send_frame(16'sh4000, -16'sh4000, 1'b0);
    send_frame(16'sd3, -16'sd3, 1'b1);
    send_frame(16'sh7fff, 16'sh8000, 1'b0);

    // Enabled with zero percent: crawl down by one
    set_regs(17'h00001, 17'd0, 17'd1, 1'b0);
    send_frame(16'sh7fff, 16'sh8000, 1'b0);
    send_frame(-16'sd1, 16'sd1, 1'b1);

    // Step far beyond the distance lands exactly on a one percent target
    set_regs(17'h00001, 17'd1, 17'h0ffff, 1'b0);
    send_frame(16'sh7fff, 16'sh8000, 1'b0);
    send_frame(16'sd50, -16'sd50, 1'b0);
    send_frame(16'sd51, -16'sd51, 1'b1);

    // Slow ramp up toward an odd target
    set_regs(17'h00001, 17'd37, 17'd3, 1'b0);
    send_frame(16'sh7fff, 16'sh8000, 1'b0);
    send_frame(16'sh2aaa, -16'sh2aab, 1'b0);
    send_frame(16'sd1, -16'sd1, 1'b1);

    // Random settings, each held for a random number of frames
    while (frames_sent < FrameTarget) begin
      en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 5))
        0:       pct = '0;
        1:       pct = PctWidth'(PctMax);
        2:       pct = '1;
        default: pct = PctWidth'($urandom_range(0, 127));
      endcase
      case ($urandom_range(0, 9))
        0:       step = '0;
        1:       step = '1;
        2:       step = 17'h10000;
        3, 4:    step = StepWidth'($urandom_range(1, 64));
        5, 6:    step = StepWidth'($urandom_range(65, 2000));
        default: step = StepWidth'($urandom_range(1, 131071));
      endcase
      set_regs({16'($urandom), en}, {10'($urandom), pct}, step,
               ($urandom_range(0, 4) == 0));
      span = $urandom_range(8, 100);
      repeat (span) send_frame(pick_sample(), pick_sample(), ($urandom_range(0, 3) == 0));
    end

    // Let the last frames drain, then give the verdict
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (frames_owed != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sgr_pkg.sv
rtl/core/sgr_gain_ramp.sv
rtl/core/sgr_scale.sv
rtl/core/stereo_gain_ramp.sv
rtl/core/sgr_checker.sv
sim/sgr_checker.sv
sim/tb.sv
